@@ sv/sha256_pkg.sv @@
`timescale 1ns / 1ps
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ sv/sha256_if.sv @@
`timescale 1ns / 1ps
interface sha256_in_if import sha256_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if import sha256_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/sha256_round.sv @@
`timescale 1ns / 1ps
module sha256_round import sha256_pkg::*; (
  input  logic [255:0] vars_i,
  input  logic [31:0]  k_i,
  input  logic [31:0]  w_i,
  output logic [255:0] vars_o
);
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
  always_comb begin
    {a, b, c, d, e, f, g, h} = vars_i;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k_i + w_i;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    vars_o = {t1 + t2, a, b, c, d + t1, e, f, g};
  end
endmodule

@@ sv/sha256_message_hasher.sv @@
`timescale 1ns / 1ps
// sha-256 over a byte stream: one byte per item, packed into a 16-word block
// memory with a read-modify-write per byte. the block word is read during the
// accepting cycle and merged and written back in the next one. a full block
// then streams its 16 words into a 16-register schedule window, runs 64
// rounds at one round per cycle and folds into the chaining hash. on an
// ending item the padding bytes (0x80, zero fill, 64-bit bit length) go
// through the same byte path, which may close one or two blocks. then eight
// digest items follow, one per cycle while the receiver is ready. one item is
// worked at a time: the input is not ready while a byte is written, a block is
// compressed or the digest is out. the chaining hash holds eight registers.
module sha256_message_hasher import sha256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  state_e state_q, state_d;

  // block memory
  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [31:0]  hash_q [8];
  logic [255:0] vars_q, vars_next;
  logic [5:0]   pos_q, pos_d, next_pos;
  logic [63:0]  len_q, len_d, plen_q, plen_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         phase_q, phase_d;
  logic [7:0]   byte_q, byte_d;
  logic         last_q, last_d;
  logic         pad_q, pad_d;     // in padding
  logic         lenph_q, lenph_d; // padding has reached the length bytes
  logic         done_q, done_d;   // final length byte placed
  logic [31:0]  w_q [16];         // schedule window for the round
  logic [31:0]  wt;
  logic [31:0]  s0, s1, wnew;
  logic         fold_en, load_en, emit_done;
  logic [2:0]   emit_idx_q;

  // schedule window held in registers, shifted one per round
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    wt = w_q[0];
  end

  sha256_round u_round (
    .vars_i(vars_q),
    .k_i   (round_k(cnt_q[5:0])),
    .w_i   (wt),
    .vars_o(vars_next)
  );

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; len_d = len_q; plen_d = plen_q; cnt_d = cnt_q;
    phase_d = phase_q; byte_d = byte_q; last_d = last_q; pad_d = pad_q;
    lenph_d = lenph_q; done_d = done_q;
    next_pos = pos_q + 6'd1;
    rd_addr = pos_q[5:2];
    wr_en = 1'b0; wr_addr = pos_q[5:2]; wr_data = rd_q;
    in_i.ready = 1'b0;
    fold_en = 1'b0; load_en = 1'b0; emit_done = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // the word at pos_q is read in this cycle, so the merge follows directly
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.payload.has_byte) begin
            len_d = len_q + 64'd8;
            byte_d = in_i.payload.message_byte;
            last_d = in_i.payload.is_last;
            phase_d = 1'b1;
            state_d = ST_PAD;
          end else if (in_i.payload.is_last) begin
            plen_d = len_q;
            pad_d = 1'b1;
            lenph_d = 1'b0;
            byte_d = PadByte;
            phase_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // read cycle, then merge-and-write cycle
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_data[8*(2'd3 - pos_q[1:0]) +: 8] = byte_q;
          pos_d = next_pos;
          phase_d = 1'b0;
          state_d = ST_IDLE;
          // pick the next padding byte
          if (pad_q) begin
            state_d = ST_PAD;
            if (lenph_q) begin
              if (next_pos == 6'd0) begin
                done_d = 1'b1;
              end else begin
                byte_d = plen_q[8*(3'd7 - next_pos[2:0]) +: 8];
              end
            end else if (next_pos == 6'd56) begin
              lenph_d = 1'b1;
              byte_d = plen_q[63:56];
            end else begin
              byte_d = 8'h00;
            end
          end else if (last_q) begin
            plen_d = len_q;
            pad_d = 1'b1;
            lenph_d = 1'b0;
            byte_d = PadByte;
            state_d = ST_PAD;
          end
          if (pos_q == 6'd63) begin
            cnt_d = '0;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // stream 16 words into the window, data arrives in the cycle after the address
        rd_addr = cnt_q[3:0];
        if (cnt_q == 7'd0) begin
          cnt_d = 7'd1;
        end else begin
          load_en = 1'b1;
          cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'd16) begin
            cnt_d = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          cnt_d = '0;
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        fold_en = 1'b1;
        phase_d = 1'b0;
        if (done_q) begin
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_o.ready && emit_idx_q == 3'd7) begin
          emit_done = 1'b1;
          pos_d = '0; len_d = '0; pad_d = 1'b0; last_d = 1'b0;
          lenph_d = 1'b0; done_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0; len_q <= '0; cnt_q <= '0; phase_q <= 1'b0;
      last_q <= 1'b0; pad_q <= 1'b0; lenph_q <= 1'b0; done_q <= 1'b0;
      emit_idx_q <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= initial_hash(3'(i));
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; len_q <= len_d; cnt_q <= cnt_d; phase_q <= phase_d;
      last_q <= last_d; pad_q <= pad_d; lenph_q <= lenph_d; done_q <= done_d;
      if (state_q == ST_EMIT && out_o.ready) emit_idx_q <= emit_idx_q + 3'd1;
      if (emit_done) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= initial_hash(3'(i));
      end else if (fold_en) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[32*(7 - i) +: 32];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    plen_q <= plen_d;
    if (load_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= rd_q;
      vars_q <= {hash_q[0], hash_q[1], hash_q[2], hash_q[3],
                 hash_q[4], hash_q[5], hash_q[6], hash_q[7]};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
      vars_q <= vars_next;
    end
  end

  assign out_o.valid = (state_q == ST_EMIT);
  assign out_o.payload.digest_word = hash_q[emit_idx_q];
  assign out_o.payload.word_index = emit_idx_q;
  assign out_o.payload.last_word = (emit_idx_q == 3'd7);

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import sha256_pkg::*;

  logic clk_i;
  logic rst_ni;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_message_hasher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // predicted digest words, oldest first
  out_item_t digest_q[$];

  // predictor state
  logic [31:0] hash_st[8];
  logic [31:0] blk_st[16];
  logic [5:0]  fill_st;
  logic [63:0] bitlen_st;

  int unsigned errors;
  int unsigned words_seen;
  int unsigned msgs_sent;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  localparam int unsigned CycleLimit = 900000;
  localparam int unsigned DrainCycles = 200;

  // directed rows: byte, has_byte, is_last, whether the first word is typed in, that word
  typedef struct {
    logic [7:0]  b;
    logic        hb;
    logic        lst;
    logic        known;
    logic [31:0] w0;
  } dir_row_t;

  // clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] sig_big0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] sig_big1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // one compression of the assembled block into the chaining hash
  task automatic fold_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_st[i];
    for (int i = 16; i < 64; i++) begin
      s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]} ^ (w[i-15] >> 3);
      s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]} ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + sig_big1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
      t2 = sig_big0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int unsigned sh;
    sh = (3 - fill_st[1:0]) * 8;
    blk_st[fill_st[5:2]] = (blk_st[fill_st[5:2]] & ~(32'hff << sh)) | ({24'h0, b} << sh);
    fill_st = fill_st + 6'd1;
    if (fill_st == 6'd0) fold_block();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_st[i] = initial_hash(i[2:0]);
    fill_st = '0;
    bitlen_st = '0;
  endtask

  // advance the predictor by one accepted item
  task automatic predict_digest(input in_item_t it);
    logic [63:0] len;
    out_item_t o;
    if (it.has_byte) begin
      bitlen_st = bitlen_st + 64'd8;
      absorb_byte(it.message_byte);
    end
    if (it.is_last) begin
      len = bitlen_st;
      absorb_byte(PadByte);
      while (fill_st != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_st[i];
        o.word_index = i[2:0];
        o.last_word = (i == 7);
        digest_q = {digest_q, o};
      end
      restart_hash();
      msgs_sent++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, exp, cycle_cnt);
    errors++;
  endtask

  // output side: random stall, check each accepted word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", out_if.payload.digest_word, 32'h0);
        end else begin
          if (out_if.payload.digest_word !== digest_q[0].digest_word)
            report_mismatch("digest_word", out_if.payload.digest_word, digest_q[0].digest_word);
          if (out_if.payload.word_index !== digest_q[0].word_index)
            report_mismatch("word_index", 32'(out_if.payload.word_index),
                            32'(digest_q[0].word_index));
          if (out_if.payload.last_word !== digest_q[0].last_word)
            report_mismatch("last_word", 32'(out_if.payload.last_word),
                            32'(digest_q[0].last_word));
          void'(digest_q.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one item, idling at random before it; returns after acceptance
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_digest(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random message: mostly well-formed byte runs, lengths clustered near block edges
  task automatic send_message();
    int unsigned len;
    in_item_t it;
    case ($urandom_range(5))
      0: len = $urandom_range(3);
      1: len = 55 + $urandom_range(10);
      2: len = 119 + $urandom_range(10);
      default: len = $urandom_range(70);
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      it.message_byte = 8'($urandom_range(255));
      it.has_byte = 1'b1;
      it.is_last = (i == len - 1) && $urandom_range(1);
      // bare items sprinkled in as noise
      if ($urandom_range(15) == 0) begin
        it.has_byte = 1'b0;
        it.is_last = 1'b0;
      end
      send_item(it);
      if (it.is_last) return;
    end
    it.message_byte = 8'($urandom_range(255));
    it.has_byte = 1'b0;
    it.is_last = 1'b1;
    send_item(it);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n_items);
    int unsigned stop_at;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_message();
  endtask

  dir_row_t dir_tab[10];
  in_item_t dit;

  initial begin
    msgs_sent = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 16; i++) blk_st[i] = '0;
    restart_hash();
    in_if.valid = 1'b0;
    in_if.payload = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message right after reset, then "abc", then edge bytes
    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},  // bare item, no effect
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
      '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0}
    };
    foreach (dir_tab[r]) begin
      dit.message_byte = dir_tab[r].b;
      dit.has_byte = dir_tab[r].hb;
      dit.is_last = dir_tab[r].lst;
      send_item(dit);
      if (dir_tab[r].known && digest_q.size() >= 8 &&
          digest_q[digest_q.size()-8].digest_word !== dir_tab[r].w0)
        report_mismatch("predictor vs known digest",
                        digest_q[digest_q.size()-8].digest_word, dir_tab[r].w0);
    end
    // exactly 64 bytes and 56 bytes: last byte fills a block, or padding needs an extra one
    for (int i = 0; i < 64; i++) begin
      dit = '{message_byte: i[7:0], has_byte: 1'b1, is_last: (i == 63)};
      send_item(dit);
    end
    for (int i = 0; i < 56; i++) begin
      dit = '{message_byte: 8'hff - i[7:0], has_byte: 1'b1, is_last: (i == 55)};
      send_item(dit);
    end
    // sender holds off until everything is out
    wait_drained();

    run_phase(0, 0, 70);
    run_phase(74, 0, 55);
    run_phase(0, 74, 55);
    wait_drained();
    run_phase(14, 14, 70);
    recv_stall_pct = 0;

    wait_drained();
    $display("sent %0d items in %0d messages, checked %0d digest words",
             items_sent, msgs_sent, words_seen);
    $display("covered empty and block-edge lengths under sender idle and receiver stall");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_round.sv
sv/sha256_message_hasher.sv
sim/tb_top.sv
